// File: rtl/pfa_pkg.sv
// Package for the fixed-partition allocator.
// Holds codes and the control struct shared by the top level and the cells.
// No dependencies.
package pfa_pkg;

    // Request kinds carried in req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_GRANTED = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;

    // Fit policy codes (the unused code behaves as first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_FIT_POLICY  = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;

    // Configuration field widths
    localparam int POLICY_W = 2;
    localparam int COUNT_W  = 5;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                load_en;   // write size into the selected cell, free it
        logic                grant_en;  // mark the selected cell used
        logic [POLICY_W-1:0] policy;    // fit policy for the candidate compare
    } cell_ctrl_t;

endpackage

// File: rtl/partition_fit_allocator.sv
// Fixed-partition allocator top level: sequencer, configuration registers,
// output register and the chain of table cells.
// Depends on pfa_pkg and pfa_cell.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+---------------------------------------------
//  input   | in_valid / in_stall   | req_type, block_index, amount
//  output  | out_valid / out_stall | status, chosen_index, chosen_size, leftover
//  config  | wr_en                 | wr_index, wr_data
//
// A load goes from idle to the result state; an allocate passes through scan,
// grant and result, the candidate walking the cell chain one cell per cycle.
// in_stall is high while a transaction is in flight; a finished result can wait
// in the output register while the next transaction is already accepted.
// Reset clears all used marks and the registers (first fit, 16 blocks);
// block sizes are undefined until loaded. No clearing pass is needed.
module partition_fit_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  block_index,
    input  logic [15:0] amount,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  chosen_index,
    output logic [15:0] chosen_size,
    output logic [15:0] leftover,
    // configuration
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [4:0]  wr_data
);
    import pfa_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(NUM_BLOCKS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [SIZE_BITS-1:0]  amt_reg;
    logic [POLICY_W-1:0]   policy_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [1:0]            res_status_reg;
    logic [IDX_W-1:0]      res_index_reg;
    logic [SIZE_BITS-1:0]  res_size_reg;
    logic [SIZE_BITS-1:0]  res_left_reg;
    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [3:0]            chosen_index_reg;
    logic [15:0]           chosen_size_reg;
    logic [15:0]           leftover_reg;

    logic                  accept;
    logic                  load_hit;
    logic                  out_free;
    cell_ctrl_t            ctrl;
    logic [IDX_W-1:0]      sel_index;
    logic [SIZE_BITS-1:0]  in_amount;

    // Chain taps: entry 0 is the empty candidate fed into the first cell
    logic                  found_w [NUM_BLOCKS+1];
    logic [IDX_W-1:0]      index_w [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0]  size_w  [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0]  left_w  [NUM_BLOCKS+1];

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_amount = SIZE_BITS'(amount);
    assign load_hit  = (int'(block_index) < NUM_BLOCKS);

    // Broadcast to the cells: load in idle, grant once the scan has finished
    always_comb
    begin
        ctrl.load_en  = accept && (req_type == REQ_LOAD) && load_hit;
        ctrl.grant_en = (state_reg == S_GRANT) && found_w[NUM_BLOCKS];
        ctrl.policy   = policy_reg;
        if (state_reg == S_GRANT)
        begin
            sel_index = index_w[NUM_BLOCKS];
        end
        else
        begin
            sel_index = IDX_W'(block_index);
        end
    end

    assign found_w[0] = 1'b0;
    assign index_w[0] = '0;
    assign size_w[0]  = '0;
    assign left_w[0]  = '0;

    // Cell chain
    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        pfa_cell #(
            .CELL_IDX  (i),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .sel_index   (sel_index),
            .load_size   (in_amount),
            .req_amount  (amt_reg),
            .block_count (count_reg),
            .prev_found  (found_w[i]),
            .prev_index  (index_w[i]),
            .prev_size   (size_w[i]),
            .prev_left   (left_w[i]),
            .cand_found  (found_w[i+1]),
            .cand_index  (index_w[i+1]),
            .cand_size   (size_w[i+1]),
            .cand_left   (left_w[i+1])
        );
    end

    // Sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            amt_reg          <= '0;
            policy_reg       <= POL_FIRST;
            count_reg        <= COUNT_W'(16);
            res_status_reg   <= ST_LOADED;
            res_index_reg    <= '0;
            res_size_reg     <= '0;
            res_left_reg     <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ST_LOADED;
            chosen_index_reg <= '0;
            chosen_size_reg  <= '0;
            leftover_reg     <= '0;
        end
        else
        begin
            // configuration writes
            if (wr_en)
            begin
                case (wr_index)
                    REG_FIT_POLICY:  policy_reg <= wr_data[POLICY_W-1:0];
                    REG_BLOCK_COUNT: count_reg  <= wr_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end

            // output slot drains when taken
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_LOAD)
                        begin
                            res_status_reg <= ST_LOADED;
                            res_index_reg  <= '0;
                            res_size_reg   <= '0;
                            res_left_reg   <= '0;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            amt_reg   <= in_amount;
                            cnt_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CNT)
                    begin
                        state_reg <= S_GRANT;
                    end
                end
                S_GRANT:
                begin
                    if (found_w[NUM_BLOCKS])
                    begin
                        res_status_reg <= ST_GRANTED;
                        res_index_reg  <= index_w[NUM_BLOCKS];
                        res_size_reg   <= size_w[NUM_BLOCKS];
                        res_left_reg   <= left_w[NUM_BLOCKS];
                    end
                    else
                    begin
                        res_status_reg <= ST_NOFIT;
                        res_index_reg  <= '0;
                        res_size_reg   <= '0;
                        res_left_reg   <= '0;
                    end
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= res_status_reg;
                        chosen_index_reg <= 4'(res_index_reg);
                        chosen_size_reg  <= 16'(res_size_reg);
                        leftover_reg     <= 16'(res_left_reg);
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_index_reg;
    assign chosen_size  = chosen_size_reg;
    assign leftover     = leftover_reg;

`ifndef SYNTHESIS
    // A new result only appears when the sequencer hands one over
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("output valid rose outside result hand-over");

    // Load and no-fit results carry zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_GRANTED) |->
            (chosen_index_reg == 4'd0) && (chosen_size_reg == 16'd0)
            && (leftover_reg == 16'd0))
        else $error("non-grant result with nonzero fields");

    // A scan runs through the whole chain before granting
    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT) |-> $past(state_reg == S_SCAN)
            && $past(cnt_reg == LAST_CNT))
        else $error("grant reached before the chain was walked");
`endif

endmodule

// File: rtl/pfa_cell.sv
// One block of the partition table: its size, its used mark and one stage
// of the candidate chain that walks the table during an allocate scan.
// Depends on pfa_pkg.
module pfa_cell #(
    parameter int CELL_IDX  = 0,
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfa_pkg::cell_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]       sel_index,
    input  logic [SIZE_BITS-1:0]   load_size,
    input  logic [SIZE_BITS-1:0]   req_amount,
    input  logic [pfa_pkg::COUNT_W-1:0] block_count,
    // candidate from the previous cell
    input  logic                   prev_found,
    input  logic [IDX_W-1:0]       prev_index,
    input  logic [SIZE_BITS-1:0]   prev_size,
    input  logic [SIZE_BITS-1:0]   prev_left,
    // candidate handed to the next cell
    output logic                   cand_found,
    output logic [IDX_W-1:0]       cand_index,
    output logic [SIZE_BITS-1:0]   cand_size,
    output logic [SIZE_BITS-1:0]   cand_left
);
    import pfa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                 used_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     index_reg;
    logic [SIZE_BITS-1:0] csize_reg;
    logic [SIZE_BITS-1:0] left_reg;

    logic                 selected;
    logic                 in_range;
    logic                 fits;
    logic [SIZE_BITS-1:0] my_left;
    logic                 better;
    logic                 take;

    assign selected = (sel_index == MY_IDX);
    assign in_range = (CELL_IDX < int'(block_count));

    // Candidate compare: take this block if it fits and there is no incoming pick or it beats it
    assign fits    = !used_reg && in_range && (size_reg >= req_amount);
    assign my_left = size_reg - req_amount;

    always_comb
    begin
        case (ctrl.policy)
            POL_BEST:  better = (my_left < prev_left);
            POL_WORST: better = (my_left > prev_left);
            default:   better = 1'b0;
        endcase
    end

    assign take = fits && (!prev_found || better);

    // Table entry: size has no reset, used mark clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.load_en && selected)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.grant_en && selected)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en && selected)
        begin
            size_reg <= load_size;
        end
    end

    // Chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= prev_found || take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            index_reg <= MY_IDX;
            csize_reg <= size_reg;
            left_reg  <= my_left;
        end
        else
        begin
            index_reg <= prev_index;
            csize_reg <= prev_size;
            left_reg  <= prev_left;
        end
    end

    assign cand_found = found_reg;
    assign cand_index = index_reg;
    assign cand_size  = csize_reg;
    assign cand_left  = left_reg;

endmodule
